// ----- rtl/rc3n_pkg.sv -----
// ----------------------------------------------------------------------------
// rc3n_pkg
// Shared types and constants of the RGBA 3x3 normalized convolution core.
// ----------------------------------------------------------------------------
package rc3n_pkg;

    localparam int PIX_W      = 8;          // one color channel
    localparam int RGB_W      = 24;         // packed R, G, B
    localparam int WORD_W     = 32;         // packed R, G, B, A
    localparam int COEF_W     = 16;         // signed Q8.8 coefficient
    localparam int KROW_W     = 48;         // three coefficients of one kernel row
    localparam int SCALE_W    = 24;         // signed Q8.16 normalization factor
    localparam int ACC_W      = 28;         // nine taps of 8 x 16 bits, signed
    localparam int PROD_W     = 52;         // sum times factor, signed
    localparam int RND_SHIFT  = 24;         // Q8.8 * Q8.16 -> integer
    localparam int WID_REG_W  = 11;         // image_width register
    localparam int ROW_W      = 13;         // image_height register and row counter
    localparam int MAX_HEIGHT = 4096;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 52'sh0000000800000;
    localparam logic [PIX_W-1:0]         PIX_MAX    = 8'hFF;

    // input item kind carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // register indexes (paddr / 8)
    localparam logic [2:0] REG_KTOP   = 3'd0;
    localparam logic [2:0] REG_KMID   = 3'd1;
    localparam logic [2:0] REG_KBOT   = 3'd2;
    localparam logic [2:0] REG_SCALE  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    localparam logic [KROW_W-1:0]  KTOP_RST  = 48'h000000000000;
    localparam logic [KROW_W-1:0]  KMID_RST  = 48'h000001000000;
    localparam logic [KROW_W-1:0]  KBOT_RST  = 48'h000000000000;
    localparam logic [SCALE_W-1:0] SCALE_RST = 24'h010000;
    localparam logic [ROW_W-1:0]   HGT_RST   = 13'd1024;
    localparam logic [WID_REG_W-1:0] WID_RAW_RST = 11'd1024;

    // kernel tap walk
    localparam logic [1:0] TAP_FIRST = 2'd0;
    localparam logic [1:0] TAP_LAST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_READ,
        ST_LOAD,
        ST_MAC,
        ST_SCALE,
        ST_ROUND
    } t_state;

    // 3x3 window, [row][column], column 2 newest
    typedef logic [2:0][2:0][RGB_W-1:0] t_win;
    typedef logic [2:0][2:0][PIX_W-1:0] t_win8;

    typedef struct packed {
        logic bot_en;
        logic mid_en;
        logic top_en;
        logic emit;
        logic zl;
        logic zr;
        logic last;
    } t_flags;

    typedef struct packed {
        logic rd;
        logic wr;
        logic bot_en;
        logic mid_en;
        logic top_en;
    } t_line_ctl;

    typedef struct packed {
        logic       clr;
        logic       mac;
        logic       skip;
        logic       scale;
        logic [1:0] row;
        logic [1:0] col;
    } t_lane_ctl;

endpackage

// ----- rtl/rgba_conv3x3_normalized_core.sv -----
// ----------------------------------------------------------------------------
// rgba_conv3x3_normalized_core
// Streaming 3x3 convolution of RGBA pixels with normalization and clamping.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel in raster order, one transfer each;
//   tuser=1 marks a drain item that stands for the zero row below the image.
//   After the last pixel, send image_width+1 drain items to flush the frame.
//   A result leaves on m_axis image_width+1 transfers after its pixel went in;
//   tlast marks the last result of a frame, after which a new frame starts.
//   Kernel, scale and geometry are to be written over the APB port while idle; the core does not enforce this.
// Sequence:
//   One item is handled at a time. An item that yields no result passes
//   through accept, position, line read and line write. An item with a
//   result adds a multiply-accumulate walk over the 3x3 taps (one shared
//   multiplier per color lane), a scaling step and an output step, after
//   which the next item can be accepted.
// Reset:
//   Synchronous, active low. Clears counters, window, alpha and output valid
//   and restores default registers. The line store is not cleared.
// Backpressure:
//   The result sits in an output register; the next item is taken meanwhile
//   and only waits in its last step while that register is still full.
// ----------------------------------------------------------------------------
module rgba_conv3x3_normalized_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input pixels
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,   // red, green, blue, alpha
    input  logic [0:0]                          s_axis_tuser,   // opcode
    // filtered pixels
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // red, green, blue, alpha
    output logic                                m_axis_tlast,   // frame_last
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rc3n_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rc3n_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rc3n_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int WID_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // ---------------- configuration registers ----------------
    logic [rc3n_pkg::KROW_W-1:0]    r_kern [3];
    logic [rc3n_pkg::SCALE_W-1:0]   r_scale;
    logic [rc3n_pkg::WID_REG_W-1:0] r_wid_raw;
    logic [rc3n_pkg::ROW_W-1:0]     r_hgt_raw;
    logic [WW-1:0]                  r_wid_eff;   // saturated to 1..MAX_WIDTH
    logic [rc3n_pkg::ROW_W-1:0]     r_hgt_eff;   // saturated to 1..MAX_HEIGHT

    logic                           cfg_wr;
    logic [2:0]                     reg_sel;
    logic [rc3n_pkg::WID_REG_W-1:0] wid_in;
    logic [rc3n_pkg::ROW_W-1:0]     hgt_in;
    logic [WW-1:0]                  wid_sat;
    logic [rc3n_pkg::ROW_W-1:0]     hgt_sat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[rc3n_pkg::APB_ADDR_W-1:3];
    assign wid_in  = pwdata[rc3n_pkg::WID_REG_W-1:0];
    assign hgt_in  = pwdata[rc3n_pkg::ROW_W-1:0];

    always_comb begin
        if (wid_in == '0) begin
            wid_sat = WW'(1);
        end else if (32'(wid_in) > MAX_WIDTH) begin
            wid_sat = WW'(MAX_WIDTH);
        end else begin
            wid_sat = WW'(wid_in);
        end
        if (hgt_in == '0) begin
            hgt_sat = rc3n_pkg::ROW_W'(1);
        end else if (hgt_in > rc3n_pkg::ROW_W'(rc3n_pkg::MAX_HEIGHT)) begin
            hgt_sat = rc3n_pkg::ROW_W'(rc3n_pkg::MAX_HEIGHT);
        end else begin
            hgt_sat = hgt_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern[0] <= rc3n_pkg::KTOP_RST;
            r_kern[1] <= rc3n_pkg::KMID_RST;
            r_kern[2] <= rc3n_pkg::KBOT_RST;
            r_scale   <= rc3n_pkg::SCALE_RST;
            r_wid_raw <= rc3n_pkg::WID_RAW_RST;
            r_wid_eff <= WW'(WID_RST);
            r_hgt_raw <= rc3n_pkg::HGT_RST;
            r_hgt_eff <= rc3n_pkg::HGT_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                rc3n_pkg::REG_KTOP:   r_kern[0] <= pwdata[rc3n_pkg::KROW_W-1:0];
                rc3n_pkg::REG_KMID:   r_kern[1] <= pwdata[rc3n_pkg::KROW_W-1:0];
                rc3n_pkg::REG_KBOT:   r_kern[2] <= pwdata[rc3n_pkg::KROW_W-1:0];
                rc3n_pkg::REG_SCALE:  r_scale   <= pwdata[rc3n_pkg::SCALE_W-1:0];
                rc3n_pkg::REG_WIDTH: begin
                    r_wid_raw <= wid_in;
                    r_wid_eff <= wid_sat;
                end
                rc3n_pkg::REG_HEIGHT: begin
                    r_hgt_raw <= hgt_in;
                    r_hgt_eff <= hgt_sat;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            rc3n_pkg::REG_KTOP:   prdata = rc3n_pkg::APB_DATA_W'(r_kern[0]);
            rc3n_pkg::REG_KMID:   prdata = rc3n_pkg::APB_DATA_W'(r_kern[1]);
            rc3n_pkg::REG_KBOT:   prdata = rc3n_pkg::APB_DATA_W'(r_kern[2]);
            rc3n_pkg::REG_SCALE:  prdata = rc3n_pkg::APB_DATA_W'(r_scale);
            rc3n_pkg::REG_WIDTH:  prdata = rc3n_pkg::APB_DATA_W'(r_wid_raw);
            rc3n_pkg::REG_HEIGHT: prdata = rc3n_pkg::APB_DATA_W'(r_hgt_raw);
            default:              prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    rc3n_pkg::t_state            r_state;
    rc3n_pkg::t_state            n_state;
    logic [AW-1:0]               r_col;      // position of the next item
    logic [rc3n_pkg::ROW_W-1:0]  r_row;
    logic [AW-1:0]               r_ci;       // position of the current item
    logic [rc3n_pkg::ROW_W-1:0]  r_ri;
    logic                        r_opcode;
    logic [rc3n_pkg::WORD_W-1:0] r_pix;
    rc3n_pkg::t_flags            r_flags;
    logic [1:0]                  r_trow;     // kernel tap being accumulated
    logic [1:0]                  r_tcol;

    logic [AW-1:0]               n_ci;
    logic [rc3n_pkg::ROW_W-1:0]  n_ri;
    rc3n_pkg::t_flags            n_flags;
    logic [AW-1:0]               n_col;
    logic [rc3n_pkg::ROW_W-1:0]  n_row;

    logic                        s_accept;
    logic                        col_wrap;
    logic [rc3n_pkg::ROW_W-1:0]  row_a;
    logic                        ci_zero;
    logic                        row_end;
    logic                        tap_last;
    logic                        mrg_free;
    logic                        mrg_load;

    rc3n_pkg::t_line_ctl         line_ctl;
    rc3n_pkg::t_lane_ctl         lane_ctl;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign tap_last = (r_trow == rc3n_pkg::TAP_LAST) && (r_tcol == rc3n_pkg::TAP_LAST);

    // Position of the current item. A column at or past the width wraps to
    // the next row; a row past the padding row starts a new frame.
    always_comb begin
        col_wrap = WW'(r_col) >= r_wid_eff;
        row_a    = col_wrap ? r_row + rc3n_pkg::ROW_W'(1) : r_row;
        n_ci     = col_wrap ? '0 : r_col;
        n_ri     = (row_a > r_hgt_eff + rc3n_pkg::ROW_W'(1)) ? '0 : row_a;
    end

    // What the current item does. Its result is the pixel one row up and one
    // column left; at column zero that is the right edge of two rows up.
    always_comb begin
        ci_zero        = (r_ci == '0);
        n_flags.bot_en = (r_opcode == rc3n_pkg::OP_PIXEL) && (r_ri < r_hgt_eff);
        n_flags.mid_en = (r_ri != '0);
        n_flags.top_en = (r_ri >= rc3n_pkg::ROW_W'(2));
        n_flags.emit   = ci_zero
                       ? ((r_ri >= rc3n_pkg::ROW_W'(2)) &&
                          (r_ri < r_hgt_eff + rc3n_pkg::ROW_W'(2)))
                       : ((r_ri != '0) && (r_ri <= r_hgt_eff));
        n_flags.zl     = ci_zero ? (r_wid_eff == WW'(1)) : (r_ci == AW'(1));
        n_flags.zr     = ci_zero;
        n_flags.last   = ci_zero && (r_ri == r_hgt_eff + rc3n_pkg::ROW_W'(1));

        row_end = (WW'(r_ci) + WW'(1)) == r_wid_eff;
        if (n_flags.last) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_ri + rc3n_pkg::ROW_W'(1);
        end else begin
            n_col = r_ci + AW'(1);
            n_row = r_ri;
        end
    end

    // next state
    always_comb begin
        case (r_state)
            rc3n_pkg::ST_IDLE:  n_state = s_axis_tvalid ? rc3n_pkg::ST_POS : rc3n_pkg::ST_IDLE;
            rc3n_pkg::ST_POS:   n_state = rc3n_pkg::ST_READ;
            rc3n_pkg::ST_READ:  n_state = rc3n_pkg::ST_LOAD;
            rc3n_pkg::ST_LOAD:  n_state = r_flags.emit ? rc3n_pkg::ST_MAC : rc3n_pkg::ST_IDLE;
            rc3n_pkg::ST_MAC:   n_state = tap_last ? rc3n_pkg::ST_SCALE : rc3n_pkg::ST_MAC;
            rc3n_pkg::ST_SCALE: n_state = rc3n_pkg::ST_ROUND;
            rc3n_pkg::ST_ROUND: n_state = mrg_free ? rc3n_pkg::ST_IDLE : rc3n_pkg::ST_ROUND;
            default:            n_state = rc3n_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready   = (r_state == rc3n_pkg::ST_IDLE);
        line_ctl.rd     = (r_state == rc3n_pkg::ST_READ);
        line_ctl.wr     = (r_state == rc3n_pkg::ST_LOAD);
        line_ctl.bot_en = r_flags.bot_en;
        line_ctl.mid_en = r_flags.mid_en;
        line_ctl.top_en = r_flags.top_en;
        lane_ctl.clr    = (r_state == rc3n_pkg::ST_LOAD);
        lane_ctl.mac    = (r_state == rc3n_pkg::ST_MAC);
        lane_ctl.scale  = (r_state == rc3n_pkg::ST_SCALE);
        lane_ctl.skip   = ((r_tcol == rc3n_pkg::TAP_FIRST) && r_flags.zl) ||
                          ((r_tcol == rc3n_pkg::TAP_LAST) && r_flags.zr);
        lane_ctl.row    = r_trow;
        lane_ctl.col    = r_tcol;
        mrg_load        = (r_state == rc3n_pkg::ST_ROUND) && mrg_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc3n_pkg::ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_flags <= '0;
            r_trow  <= rc3n_pkg::TAP_FIRST;
            r_tcol  <= rc3n_pkg::TAP_FIRST;
        end else begin
            r_state <= n_state;
            if (r_state == rc3n_pkg::ST_READ) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_flags <= n_flags;
            end
            if (r_state == rc3n_pkg::ST_LOAD) begin
                r_trow <= rc3n_pkg::TAP_FIRST;
                r_tcol <= rc3n_pkg::TAP_FIRST;
            end else if (r_state == rc3n_pkg::ST_MAC) begin
                if (r_tcol == rc3n_pkg::TAP_LAST) begin
                    r_tcol <= rc3n_pkg::TAP_FIRST;
                    if (r_trow != rc3n_pkg::TAP_LAST) begin
                        r_trow <= r_trow + 2'd1;
                    end
                end else begin
                    r_tcol <= r_tcol + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_opcode <= s_axis_tuser[0];
            r_pix    <= s_axis_tdata;
        end
        if (r_state == rc3n_pkg::ST_POS) begin
            r_ci <= n_ci;
            r_ri <= n_ri;
        end
    end

    // ---------------- line store and window ----------------
    rc3n_pkg::t_win             win;
    logic [rc3n_pkg::PIX_W-1:0] out_alpha;

    rc3n_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (line_ctl),
        .i_addr  (r_ci),
        .i_pixel (r_pix),
        .o_win   (win),
        .o_alpha (out_alpha)
    );

    // ---------------- color lanes ----------------
    // Coefficient of the current tap is shared by all three lanes.
    logic signed [rc3n_pkg::COEF_W-1:0] tap_coef;
    logic [2:0][rc3n_pkg::PIX_W-1:0]    lane_pix;

    assign tap_coef = $signed(r_kern[r_trow][rc3n_pkg::COEF_W*r_tcol +: rc3n_pkg::COEF_W]);

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rc3n_pkg::t_win8 lane_win;

        always_comb begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    lane_win[r][c] = win[r][c][rc3n_pkg::PIX_W*ch +: rc3n_pkg::PIX_W];
                end
            end
        end

        rc3n_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_win   (lane_win),
            .i_coef  (tap_coef),
            .i_scale ($signed(r_scale)),
            .o_pix   (lane_pix[ch])
        );
    end

    // ---------------- output merge ----------------
    rc3n_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mrg_load),
        .i_rgb    (lane_pix),
        .i_alpha  (out_alpha),
        .i_last   (r_flags.last),
        .i_tready (m_axis_tready),
        .o_free   (mrg_free),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/rc3n_window.sv -----
// ----------------------------------------------------------------------------
// rc3n_window
// Two-line pixel store and 3x3 window registers with centre alpha tracking.
// ----------------------------------------------------------------------------
module rc3n_window #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rc3n_pkg::t_line_ctl            i_ctl,
    input  logic [AW-1:0]                  i_addr,
    input  logic [rc3n_pkg::WORD_W-1:0]    i_pixel,
    output rc3n_pkg::t_win                 o_win,
    output logic [rc3n_pkg::PIX_W-1:0]     o_alpha
);

    // each entry: {older line, previous line}
    logic [2*rc3n_pkg::WORD_W-1:0] mem [MAX_WIDTH];
    logic [2*rc3n_pkg::WORD_W-1:0] r_rdata;
    logic [rc3n_pkg::WORD_W-1:0]   line0;
    logic [rc3n_pkg::WORD_W-1:0]   line1;
    logic [rc3n_pkg::WORD_W-1:0]   bottom;
    logic [rc3n_pkg::WORD_W-1:0]   mid;
    logic [rc3n_pkg::WORD_W-1:0]   top;
    rc3n_pkg::t_win                r_win;
    logic [rc3n_pkg::PIX_W-1:0]    r_centre;
    logic [rc3n_pkg::PIX_W-1:0]    r_alpha;

    assign line0  = r_rdata[rc3n_pkg::WORD_W-1:0];
    assign line1  = r_rdata[2*rc3n_pkg::WORD_W-1:rc3n_pkg::WORD_W];
    assign bottom = i_ctl.bot_en ? i_pixel : '0;
    assign mid    = i_ctl.mid_en ? line0 : '0;
    assign top    = i_ctl.top_en ? line1 : '0;

    // lines move down by one on each write
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= mem[i_addr];
        end
        if (i_ctl.wr) begin
            mem[i_addr] <= {line0, bottom};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_centre <= '0;
            r_alpha  <= '0;
        end else if (i_ctl.wr) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= top[rc3n_pkg::RGB_W-1:0];
            r_win[1][2] <= mid[rc3n_pkg::RGB_W-1:0];
            r_win[2][2] <= bottom[rc3n_pkg::RGB_W-1:0];
            r_alpha     <= r_centre;
            r_centre    <= mid[rc3n_pkg::WORD_W-1:rc3n_pkg::RGB_W];
        end
    end

    assign o_win   = r_win;
    assign o_alpha = r_alpha;

endmodule

// ----- rtl/rc3n_lane.sv -----
// ----------------------------------------------------------------------------
// rc3n_lane
// One color lane: serial 3x3 multiply-accumulate, scaling, rounding, clamping.
// ----------------------------------------------------------------------------
module rc3n_lane (
    input  logic                                 i_clk,
    input  rc3n_pkg::t_lane_ctl                  i_ctl,
    input  rc3n_pkg::t_win8                      i_win,
    input  logic signed [rc3n_pkg::COEF_W-1:0]   i_coef,
    input  logic signed [rc3n_pkg::SCALE_W-1:0]  i_scale,
    output logic [rc3n_pkg::PIX_W-1:0]           o_pix
);

    logic [rc3n_pkg::PIX_W-1:0]                         tap_pix;
    logic signed [rc3n_pkg::PIX_W+rc3n_pkg::COEF_W:0]   tap_prod;
    logic signed [rc3n_pkg::ACC_W-1:0]                  r_acc;
    logic signed [rc3n_pkg::PROD_W-1:0]                 r_prod;
    logic signed [rc3n_pkg::PROD_W-1:0]                 rnd;

    // padding columns at the image edges contribute nothing
    assign tap_pix  = i_ctl.skip ? '0 : i_win[i_ctl.row][i_ctl.col];
    assign tap_prod = $signed({1'b0, tap_pix}) * i_coef;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + rc3n_pkg::ACC_W'(tap_prod);
        end
        if (i_ctl.scale) begin
            r_prod <= r_acc * i_scale;
        end
    end

    // round half away from zero; non-positive results clamp to zero
    assign rnd = r_prod + rc3n_pkg::ROUND_HALF;

    always_comb begin
        if (r_prod[rc3n_pkg::PROD_W-1] || (r_prod == '0)) begin
            o_pix = '0;
        end else if (|rnd[rc3n_pkg::PROD_W-1:rc3n_pkg::RND_SHIFT+rc3n_pkg::PIX_W]) begin
            o_pix = rc3n_pkg::PIX_MAX;
        end else begin
            o_pix = rnd[rc3n_pkg::RND_SHIFT+rc3n_pkg::PIX_W-1:rc3n_pkg::RND_SHIFT];
        end
    end

endmodule

// ----- rtl/rc3n_merge.sv -----
// ----------------------------------------------------------------------------
// rc3n_merge
// Joins the three lane results with alpha and frame end into the output register.
// ----------------------------------------------------------------------------
module rc3n_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [2:0][rc3n_pkg::PIX_W-1:0] i_rgb,
    input  logic [rc3n_pkg::PIX_W-1:0]    i_alpha,
    input  logic                          i_last,
    input  logic                          i_tready,
    output logic                          o_free,
    output logic                          o_tvalid,
    output logic [rc3n_pkg::WORD_W-1:0]   o_tdata,   // red, green, blue, alpha
    output logic                          o_tlast
);

    logic                        r_valid;
    logic [rc3n_pkg::WORD_W-1:0] r_data;
    logic                        r_last;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_alpha, i_rgb[2], i_rgb[1], i_rgb[0]};
            r_last <= i_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

// ----- rtl/rc3n_checker.sv -----
// ----------------------------------------------------------------------------
// rc3n_checker
// Port-level checks of the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
module rc3n_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // after reset: no result pending, input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("core not idle after reset");

    // one item at a time: input closes after each transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // a new result only appears at the end of an item's processing
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while input was open");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output transfer changed");

endmodule

bind rgba_conv3x3_normalized_core rc3n_checker u_rc3n_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams RGBA frames through the 3x3 normalized convolution core and checks
// every filtered pixel against a window-level predictor. A directed part
// covers data, coefficient, scale and geometry corners. A random part runs
// many small frames with random kernels under rotating flow control.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_W      = 1024;
    localparam int SETTLE_CYC = 24;     // longer than one item
    localparam int HOLD_CYC   = 300;    // long sink hold-off
    localparam int GAP_MAX    = 8;      // longest source gap per item
    localparam int WDOG_LIMIT = 4000;   // cycles without any transfer
    localparam int RAND_ITEMS = 1100;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
        bit       last;
    } t_pix;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers, line store and window,
    // predicts the filtered pixel caused by each input transfer, and checks
    // output transfers in order.
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        bit [rc3n_pkg::KROW_W-1:0]         krow [3];
        bit signed [rc3n_pkg::SCALE_W-1:0] scale;
        bit [rc3n_pkg::WID_REG_W-1:0]      wid_reg;
        bit [rc3n_pkg::ROW_W-1:0]          hgt_reg;
        bit [rc3n_pkg::WORD_W-1:0]         line_mem [2*MAX_W];
        bit [rc3n_pkg::RGB_W-1:0]          win [3][3];      // [row][col], col 2 newest
        int unsigned                       col_pos;
        int unsigned                       row_pos;
        bit [7:0]                          centre_a;
        t_pix                              filtered_q [$];
        int                                err_cnt;
        int                                frames_done;

        function new();
            krow[0] = rc3n_pkg::KTOP_RST;
            krow[1] = rc3n_pkg::KMID_RST;
            krow[2] = rc3n_pkg::KBOT_RST;
            scale   = rc3n_pkg::SCALE_RST;
            wid_reg = rc3n_pkg::WID_RAW_RST;
            hgt_reg = rc3n_pkg::HGT_RST;
        endfunction

        function void set_reg(bit [2:0] idx, bit [63:0] v);
            case (idx)
                rc3n_pkg::REG_KTOP:   krow[0] = v[rc3n_pkg::KROW_W-1:0];
                rc3n_pkg::REG_KMID:   krow[1] = v[rc3n_pkg::KROW_W-1:0];
                rc3n_pkg::REG_KBOT:   krow[2] = v[rc3n_pkg::KROW_W-1:0];
                rc3n_pkg::REG_SCALE:  scale   = v[rc3n_pkg::SCALE_W-1:0];
                rc3n_pkg::REG_WIDTH:  wid_reg = v[rc3n_pkg::WID_REG_W-1:0];
                rc3n_pkg::REG_HEIGHT: hgt_reg = v[rc3n_pkg::ROW_W-1:0];
                default: ;
            endcase
        endfunction

        // one color lane: exact MAC, scale, round half up on positives, clamp
        function bit [7:0] filter_lane(int sh, bit zl, bit zr);
            longint                           acc;
            longint                           prod;
            bit signed [rc3n_pkg::COEF_W-1:0] c;
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    if ((k == 0 && zl) || (k == 2 && zr))
                        continue;
                    c = krow[r][rc3n_pkg::COEF_W*k +: rc3n_pkg::COEF_W];
                    acc += longint'(win[r][k][sh +: 8]) * longint'(c);
                end
            end
            prod = acc * longint'(scale);
            if (prod <= 0)
                return 8'd0;
            prod = (prod + (longint'(1) <<< 23)) >>> rc3n_pkg::RND_SHIFT;
            return (prod > 255) ? rc3n_pkg::PIX_MAX : prod[7:0];
        endfunction

        function void note_pixel(bit op, bit [31:0] word);
            int unsigned w, h, ci, ri, cc;
            int          cr;
            bit [31:0]   bot, mid, top;
            bit [7:0]    a_out;
            bit          zl, zr, fin;
            t_pix        res;
            w = 32'(wid_reg);
            h = 32'(hgt_reg);
            if (w < 1) w = 1;
            if (w > MAX_W) w = MAX_W;
            if (h < 1) h = 1;
            if (h > rc3n_pkg::MAX_HEIGHT) h = rc3n_pkg::MAX_HEIGHT;
            // geometry may have shrunk since the last item
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos > h + 1)
                row_pos = 0;
            ci = col_pos;
            ri = row_pos;
            // drains and anything below the image enter as zero
            bot = (op == rc3n_pkg::OP_PIXEL && ri < h) ? word : '0;
            mid = (ri >= 1) ? line_mem[ci] : '0;
            top = (ri >= 2) ? line_mem[MAX_W + ci] : '0;
            line_mem[MAX_W + ci] = line_mem[ci];
            line_mem[ci] = bot;
            a_out    = centre_a;
            centre_a = mid[31:24];
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = top[23:0];
            win[1][2] = mid[23:0];
            win[2][2] = bot[23:0];
            // window centre sits one column and one row behind the input
            cc = (ci == 0) ? w - 1 : ci - 1;
            cr = (ci == 0) ? int'(ri) - 2 : int'(ri) - 1;
            col_pos = ci + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = ri + 1;
            end
            if (cr < 0 || cr >= int'(h))
                return;
            zl  = (cc == 0);
            zr  = (cc == w - 1);
            fin = (cr == int'(h) - 1) && zr;
            res.red   = filter_lane(0, zl, zr);
            res.green = filter_lane(8, zl, zr);
            res.blue  = filter_lane(16, zl, zr);
            res.alpha = a_out;
            res.last  = fin;
            filtered_q.push_back(res);
            if (fin) begin
                col_pos = 0;
                row_pos = 0;
                frames_done++;
            end
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                err_cnt++;
            end
        endfunction

        function void check_pixel(bit [31:0] data, bit last);
            t_pix want;
            if (filtered_q.size() == 0) begin
                $error("output transfer with nothing expected: data %h last %0d", data, last);
                err_cnt++;
                return;
            end
            want = filtered_q.pop_front();
            check_field("red_out", int'(want.red), int'(data[7:0]));
            check_field("green_out", int'(want.green), int'(data[15:8]));
            check_field("blue_out", int'(want.blue), int'(data[23:16]));
            check_field("alpha_out", int'(want.alpha), int'(data[31:24]));
            check_field("frame_last", int'(want.last), int'(last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [31:0]                     s_axis_tdata;    // red, green, blue, alpha
    logic [0:0]                      s_axis_tuser;    // opcode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [31:0]                     m_axis_tdata;    // red, green, blue, alpha
    logic                            m_axis_tlast;    // frame_last
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rc3n_pkg::APB_ADDR_W-1:0] paddr;
    logic [rc3n_pkg::APB_DATA_W-1:0] pwdata;
    logic [rc3n_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    conv_scoreboard sb = new();

    int send_idle_pct;      // chance of a source gap before each item
    int recv_stall_pct;     // chance of tready low in a cycle
    int hold_asked;         // long sink hold-offs requested so far
    int items_sent;
    int idle_cycles;

    rgba_conv3x3_normalized_core #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sink: random stalls, or one long hold-off counted here on request
    initial begin
        int hold_given;
        hold_given    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_given) begin
                hold_given++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // watchdog: any transfer on either stream restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic set_flow(t_flow mode);
        case (mode)
            FLOW_FREE:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SRC_GAPS:    begin send_idle_pct = 47; recv_stall_pct = 0;  end
            FLOW_SINK_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default:          begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        endcase
    endtask

    // two-phase APB write; the model takes the value at the access edge
    task automatic apb_write(bit [2:0] idx, bit [63:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one input transfer; tvalid stays high into the next item unless a gap
    task automatic send_pixel(bit op, bit [31:0] word);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(op, word);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.filtered_q.size() != 0)
            @(posedge i_clk);
    endtask

    // idle point: all results in, plus time for a result-less item to retire
    task automatic program_all(bit [47:0] k0, bit [47:0] k1, bit [47:0] k2,
                               bit [23:0] sc, bit [10:0] w, bit [12:0] h);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        apb_write(rc3n_pkg::REG_KTOP, 64'(k0));
        apb_write(rc3n_pkg::REG_KMID, 64'(k1));
        apb_write(rc3n_pkg::REG_KBOT, 64'(k2));
        apb_write(rc3n_pkg::REG_SCALE, 64'(sc));
        apb_write(rc3n_pkg::REG_WIDTH, 64'(w));
        apb_write(rc3n_pkg::REG_HEIGHT, 64'(h));
    endtask

    // geometry only, at an idle point
    task automatic apb_write_idle_geometry(int w, int h);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        apb_write(rc3n_pkg::REG_WIDTH, 64'(w[10:0]));
        apb_write(rc3n_pkg::REG_HEIGHT, 64'(h[12:0]));
    endtask

    // w*h pixels; some slots become drains inside the image
    task automatic send_frame(int w, int h, int hole_pct, int pause_at);
        for (int i = 0; i < w * h; i++) begin
            if (i == pause_at)
                wait_drained();
            send_pixel(($urandom_range(99) < hole_pct) ? rc3n_pkg::OP_DRAIN
                                                       : rc3n_pkg::OP_PIXEL,
                       $urandom());
        end
    endtask

    // flush until the frame's last result is predicted; some flush items are
    // pixel items below the image, which count as padding
    task automatic finish_frame(int below_pct);
        int start;
        start = sb.frames_done;
        while (sb.frames_done == start)
            send_pixel(($urandom_range(99) < below_pct) ? rc3n_pkg::OP_PIXEL
                                                        : rc3n_pkg::OP_DRAIN,
                       $urandom());
    endtask

    function automatic bit [47:0] krow3(bit [15:0] l, bit [15:0] m, bit [15:0] r);
        return {r, m, l};
    endfunction

    // random kernel and geometry, written at an idle point
    task automatic random_setup(output int w, output int h);
        bit [15:0] c [9];
        longint    s;
        longint    q;
        bit [47:0] k0, k1, k2;
        bit [23:0] sc;
        w = $urandom_range(1, 12);
        if ($urandom_range(19) == 0)
            w = $urandom_range(13, 40);
        h = $urandom_range(1, 6);
        s = 0;
        foreach (c[i]) begin
            c[i] = 16'(int'($urandom_range(1024)) - 512);
            s += longint'($signed(c[i]));
        end
        case ($urandom_range(2))
            0: begin
                // box blur, 1/9
                foreach (c[i]) c[i] = 16'h0100;
                s = 9 * 256;
            end
            default: ;
        endcase
        // Q8.16 reciprocal of the kernel sum, saturated to the register range
        if (s == 0)
            q = 65536;
        else
            q = (longint'(1) <<< 24) / s;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        k0 = krow3(c[0], c[1], c[2]);
        k1 = krow3(c[3], c[4], c[5]);
        k2 = krow3(c[6], c[7], c[8]);
        sc = q[23:0];
        // now and then fully random rows and scale
        if ($urandom_range(3) == 0) begin
            k0 = 48'({$urandom(), $urandom()});
            k1 = 48'({$urandom(), $urandom()});
            k2 = 48'({$urandom(), $urandom()});
            sc = 24'($urandom());
        end
        program_all(k0, k1, k2, sc, w[10:0], h[12:0]);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [47:0] box;
        bit [15:0] ext_c [2];
        bit [23:0] ext_s [2];
        int        w, h, img, rand_start;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_asked     = 0;
        items_sent     = 0;
        set_flow(FLOW_FREE);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        box = krow3(16'h0100, 16'h0100, 16'h0100);

        // identity kernel: data extremes, a drain inside the image, and
        // pixel items below the image during the flush
        program_all('0, rc3n_pkg::KMID_RST, '0, rc3n_pkg::SCALE_RST, 11'd3, 13'd2);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'h00000000);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'hFFFFFFFF);
        send_pixel(rc3n_pkg::OP_DRAIN, 32'hFFFFFFFF);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'hA5A55A5A);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'h5A5AA5A5);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'h807F0180);
        finish_frame(100);

        // rounding at exactly one half: scale 0.5
        program_all('0, rc3n_pkg::KMID_RST, '0, 24'h008000, 11'd2, 13'd1);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'h03030101);
        send_pixel(rc3n_pkg::OP_PIXEL, 32'hFFFEFDFC);
        finish_frame(0);

        // coefficient and scale extremes on a single white pixel
        ext_c[0] = 16'h7FFF;
        ext_c[1] = 16'h8000;
        ext_s[0] = 24'h7FFFFF;
        ext_s[1] = 24'h800000;
        foreach (ext_c[i]) begin
            foreach (ext_s[j]) begin
                program_all(krow3(ext_c[i], ext_c[i], ext_c[i]),
                            krow3(ext_c[i], ext_c[i], ext_c[i]),
                            krow3(ext_c[i], ext_c[i], ext_c[i]),
                            ext_s[j], 11'd1, 13'd1);
                send_pixel(rc3n_pkg::OP_PIXEL, 32'hFFFFFFFF);
                finish_frame(0);
            end
        end

        // zero width and height saturate to one
        program_all(box, box, box, 24'd7282, 11'd0, 13'd0);
        send_pixel(rc3n_pkg::OP_PIXEL, $urandom());
        finish_frame(0);

        // width shrinks mid-image: the current row goes on at the new width
        program_all(box, box, box, 24'd7282, 11'd6, 13'd4);
        send_frame(8, 1, 0, -1);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        apb_write(rc3n_pkg::REG_WIDTH, 64'(11'd4));
        apb_write(rc3n_pkg::REG_HEIGHT, 64'(13'd2));
        finish_frame(0);

        // height shrinks below the current row: a new image starts
        program_all(box, box, box, 24'd7282, 11'd4, 13'd6);
        send_frame(4, 6, 0, -1);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        apb_write(rc3n_pkg::REG_HEIGHT, 64'(13'd2));
        send_frame(4, 2, 0, -1);
        finish_frame(0);

        // Random frames. Flow control rotates per frame; about half the
        // frames follow the previous one with no idle point between them.
        rand_start = items_sent;
        img = 0;
        w = 1;
        h = 1;
        while (items_sent - rand_start < RAND_ITEMS) begin
            set_flow(t_flow'(img % 4));
            if (img == 0 || $urandom_range(1))
                random_setup(w, h);
            // sink holds off while the source keeps offering: input stalls
            if (img == 5) begin
                w = 12;
                h = 6;
                apb_write_idle_geometry(w, h);
                hold_asked++;
            end
            // source pauses mid-frame until every result is out
            send_frame(w, h, 4, (img == 3) ? (w * h) / 2 : -1);
            finish_frame(10);
            img++;
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.filtered_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rc3n_pkg.sv
rtl/rc3n_window.sv
rtl/rc3n_lane.sv
rtl/rc3n_merge.sv
rtl/rgba_conv3x3_normalized_core.sv
rtl/rc3n_checker.sv
dv/tb.sv
